@@ hw/rtl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and defaults of the first-fit heap block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int DEF_BLOCK_BYTES = 64;
  localparam int DEF_BLOCK_COUNT = 128;

  localparam logic [15:0] HEAP_BASE_RST = 16'hB700;
  localparam int          HEAP_BASE_W   = 16;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index as decoded from paddr[2]
  localparam logic REG_HEAP_BASE = 1'b0;

  localparam int SIZE_W  = 32;
  localparam int FADDR_W = 32;
  localparam int GRANT_W = 17;
  localparam int STAT_W  = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_ALLOC_FAIL   = 2'd1,
    STAT_ILLEGAL_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MARK_FREE   = 3'd0,
    MARK_MID    = 3'd1,
    MARK_FIRST  = 3'd2,
    MARK_LAST   = 3'd3,
    MARK_SINGLE = 3'd4
  } mark_e;

  typedef struct packed {
    logic                      operation;
    logic signed [SIZE_W-1:0]  request_size;
    logic        [FADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted_address;
    logic [STAT_W-1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_LOCATE,
    S_FCHECK,
    S_FWALK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_CLEAR,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ZERO,
    RD_CUR,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    in_load;
    logic    off_load;
    idx_op_e idx_op;
    rd_sel_e rd_sel;
    logic    scan_step;
    logic    fit_latch;
    logic    wr_zero;
    logic    wr_mark;
    logic    mark_step;
    logic    res_load;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic size_bad;
    logic off_bad;
    logic fit;
    logic last;
    logic head;
    logic tail;
    logic mark_done;
    logic loc_hit;
    logic loc_past;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/ffba_map.sv @@
// ----------------------------------------------------------------------------
// ffba_map
// Block mark memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_map #(
  parameter int BLOCK_COUNT = 128
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(BLOCK_COUNT)-1:0] wr_idx,
  input  ffba_pkg::mark_e                wr_mark,
  input  logic                           rd_en,
  input  logic [$clog2(BLOCK_COUNT)-1:0] rd_idx,
  output ffba_pkg::mark_e                rd_mark
);
  import ffba_pkg::*;

  mark_e mem [BLOCK_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mark <= mem[rd_idx];
    end
  end

endmodule

@@ hw/rtl/ffba_dp.sv @@
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: request registers, block walk counters, run tracking,
// mark memory and the result register.
// ----------------------------------------------------------------------------
module ffba_dp #(
  parameter int BLOCK_BYTES = 64,
  parameter int BLOCK_COUNT = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffba_pkg::req_t                      req,
  input  logic [ffba_pkg::HEAP_BASE_W-1:0]    heap_base,
  input  ffba_pkg::cmd_t                      cmd,
  output ffba_pkg::sts_t                      sts,
  output logic                                rsp_valid,
  output ffba_pkg::rsp_t                      rsp,
  input  logic                                rsp_stall
);
  import ffba_pkg::*;

  localparam int IDX_W      = $clog2(BLOCK_COUNT);
  localparam int HEAP_BYTES = BLOCK_COUNT * BLOCK_BYTES;
  localparam int OFF_W      = $clog2(HEAP_BYTES + 1);
  localparam int SUM_W      = (OFF_W > GRANT_W) ? OFF_W : GRANT_W;

  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(BLOCK_COUNT - 1);
  localparam logic [IDX_W-1:0]   ONE_IDX  = IDX_W'(1);
  localparam logic [OFF_W-1:0]   BB_OFF   = OFF_W'(BLOCK_BYTES);
  localparam logic [SIZE_W-1:0]  HEAP_SZ  = SIZE_W'(HEAP_BYTES);

  logic               op;
  logic [SIZE_W-1:0]  size;
  logic [FADDR_W-1:0] faddr;

  logic [IDX_W-1:0]   ev_idx;
  logic [OFF_W-1:0]   cur_off;
  logic [OFF_W-1:0]   run;
  logic [IDX_W-1:0]   start_idx;
  logic [OFF_W-1:0]   start_off;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   end_idx;
  logic [OFF_W-1:0]   off_reg;

  status_e            res_code;
  logic [GRANT_W-1:0] res_addr;

  logic [FADDR_W-1:0] off;
  logic [OFF_W-1:0]   run_plus;
  logic               blk_free;
  logic [SUM_W-1:0]   grant_sum;
  mark_e              mark_val;
  mark_e              rd_mark;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_idx;
  mark_e              mem_wr_mark;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_idx;

  // ---------------- status towards the controller
  assign off       = faddr - FADDR_W'(heap_base);
  assign run_plus  = run + BB_OFF;
  assign blk_free  = (rd_mark == MARK_FREE);

  always_comb begin
    sts           = '0;
    sts.op_free   = (op == OP_FREE);
    sts.size_bad  = size[SIZE_W-1] || (size == '0) || (size > HEAP_SZ);
    sts.off_bad   = (off >= FADDR_W'(HEAP_BYTES));
    sts.fit       = blk_free && (SIZE_W'(run_plus) >= size);
    sts.last      = (ev_idx == LAST_IDX);
    sts.head      = (rd_mark == MARK_FIRST) || (rd_mark == MARK_SINGLE);
    sts.tail      = (rd_mark == MARK_LAST) || (rd_mark == MARK_SINGLE);
    sts.mark_done = (wr_idx == end_idx);
    sts.loc_hit   = (cur_off == off_reg);
    sts.loc_past  = (cur_off > off_reg);
    sts.out_free  = !rsp_valid || !rsp_stall;
  end

  // ---------------- request registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op    <= req.operation;
      size  <= req.request_size;
      faddr <= req.free_address;
    end
    if (cmd.off_load) begin
      off_reg <= off[OFF_W-1:0];
    end
  end

  // ---------------- block walk counter, also the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_idx  <= '0;
      cur_off <= '0;
    end else begin
      unique case (cmd.idx_op)
        IDX_CLEAR: begin
          ev_idx  <= '0;
          cur_off <= '0;
        end
        IDX_INC: begin
          ev_idx  <= ev_idx + ONE_IDX;
          cur_off <= cur_off + BB_OFF;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- free run tracking during the scan
  always_ff @(posedge clk) begin
    if (cmd.idx_op == IDX_CLEAR) begin
      run <= '0;
    end else if (cmd.scan_step) begin
      run <= blk_free ? run_plus : '0;
    end
    if (cmd.scan_step && blk_free && (run == '0)) begin
      start_idx <= ev_idx;
      start_off <= cur_off;
    end
    if (cmd.fit_latch) begin
      wr_idx  <= (run == '0) ? ev_idx : start_idx;
      end_idx <= ev_idx;
    end else if (cmd.mark_step) begin
      wr_idx <= wr_idx + ONE_IDX;
    end
  end

  always_comb begin
    priority if ((wr_idx == start_idx) && (wr_idx == end_idx)) begin
      mark_val = MARK_SINGLE;
    end else if (wr_idx == start_idx) begin
      mark_val = MARK_FIRST;
    end else if (wr_idx == end_idx) begin
      mark_val = MARK_LAST;
    end else begin
      mark_val = MARK_MID;
    end
  end

  // ---------------- mark memory
  assign mem_wr_en   = cmd.wr_zero || cmd.wr_mark;
  assign mem_wr_idx  = cmd.wr_mark ? wr_idx : ev_idx;
  assign mem_wr_mark = cmd.wr_mark ? mark_val : MARK_FREE;
  assign mem_rd_en   = (cmd.rd_sel != RD_NONE);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO: mem_rd_idx = '0;
      RD_CUR:  mem_rd_idx = ev_idx;
      RD_NEXT: mem_rd_idx = ev_idx + ONE_IDX;
      default: mem_rd_idx = ev_idx;
    endcase
  end

  ffba_map #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_map (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_idx (mem_wr_idx),
    .wr_mark(mem_wr_mark),
    .rd_en  (mem_rd_en),
    .rd_idx (mem_rd_idx),
    .rd_mark(rd_mark)
  );

  // ---------------- result staging and output register
  assign grant_sum = SUM_W'(heap_base) + SUM_W'(start_off);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_code <= cmd.res_code;
      res_addr <= ((cmd.res_code == STAT_OK) && (op == OP_ALLOC)) ?
                  grant_sum[GRANT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.granted_address <= res_addr;
      rsp.status          <= res_code;
    end
  end

endmodule

@@ hw/rtl/ffba_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffba_ctrl
// Allocator sequencer: clearing sweep, allocate scan and mark, free locate
// and walk, result hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);
  import ffba_pkg::*;

  state_e state;
  state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (!sts.op_free && sts.size_bad) state_next = S_DONE;
        else if (!sts.op_free)                     state_next = S_SCAN;
        else if (sts.off_bad)                      state_next = S_DONE;
        else                                       state_next = S_LOCATE;
      end
      S_SCAN: begin
        if (sts.fit)       state_next = S_MARK;
        else if (sts.last) state_next = S_DONE;
      end
      S_MARK: begin
        if (sts.mark_done) state_next = S_DONE;
      end
      S_LOCATE: begin
        if (sts.loc_hit)       state_next = S_FCHECK;
        else if (sts.loc_past) state_next = S_DONE;
      end
      S_FCHECK: begin
        if (!sts.head || sts.tail || sts.last) state_next = S_DONE;
        else                                   state_next = S_FWALK;
      end
      S_FWALK: begin
        if (sts.tail || sts.last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.rd_sel   = RD_NONE;
    cmd.res_code = STAT_OK;
    req_stall    = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_zero = 1'b1;
        cmd.idx_op  = IDX_INC;
      end
      S_IDLE: begin
        req_stall   = 1'b0;
        cmd.in_load = req_valid;
      end
      S_CHECK: begin
        if (!sts.op_free) begin
          if (sts.size_bad) begin
            cmd.res_load = 1'b1;
            cmd.res_code = STAT_ALLOC_FAIL;
          end else begin
            cmd.idx_op = IDX_CLEAR;
            cmd.rd_sel = RD_ZERO;
          end
        end else if (sts.off_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_code = STAT_ILLEGAL_FREE;
        end else begin
          cmd.off_load = 1'b1;
          cmd.idx_op   = IDX_CLEAR;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.fit) begin
          cmd.fit_latch = 1'b1;
        end else if (sts.last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = STAT_ALLOC_FAIL;
        end else begin
          cmd.rd_sel = RD_NEXT;
          cmd.idx_op = IDX_INC;
        end
      end
      S_MARK: begin
        cmd.wr_mark   = 1'b1;
        cmd.mark_step = 1'b1;
        if (sts.mark_done) begin
          cmd.res_load = 1'b1;
          cmd.res_code = STAT_OK;
        end
      end
      S_LOCATE: begin
        if (sts.loc_hit) begin
          cmd.rd_sel = RD_CUR;
        end else if (sts.loc_past) begin
          // offset falls inside a block, not on its start
          cmd.res_load = 1'b1;
          cmd.res_code = STAT_ILLEGAL_FREE;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_FCHECK: begin
        if (!sts.head) begin
          cmd.res_load = 1'b1;
          cmd.res_code = STAT_ILLEGAL_FREE;
        end else begin
          cmd.wr_zero = 1'b1;
          if (sts.tail || sts.last) begin
            cmd.res_load = 1'b1;
            cmd.res_code = STAT_OK;
          end else begin
            cmd.rd_sel = RD_NEXT;
            cmd.idx_op = IDX_INC;
          end
        end
      end
      S_FWALK: begin
        cmd.wr_zero = 1'b1;
        if (sts.tail || sts.last) begin
          cmd.res_load = 1'b1;
          cmd.res_code = STAT_OK;
        end else begin
          cmd.rd_sel = RD_NEXT;
          cmd.idx_op = IDX_INC;
        end
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/first_fit_heap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_block_allocator
// First-fit allocator over a heap of BLOCK_COUNT blocks of BLOCK_BYTES bytes.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req  (operation, size, address)
//   rsp      out        rsp_valid / rsp_stall   rsp  (granted address, status)
//   cfg      in         APB psel/penable/pready heap_base at byte address 0
//
// One request at a time. Allocate: the request is checked, then a first-fit
// scan reads one mark a cycle, then the blocks of the run are marked.
// Free: the address is checked and the block located, then each block of the
// run is released, or a block that does not start a run is rejected.
// After reset a clearing pass empties the map before the first request is
// taken. A stalled result sits in the output register; the next request is
// taken meanwhile and holds only at its end.
// ----------------------------------------------------------------------------
module first_fit_heap_block_allocator #(
  parameter int BLOCK_BYTES = ffba_pkg::DEF_BLOCK_BYTES,
  parameter int BLOCK_COUNT = ffba_pkg::DEF_BLOCK_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  ffba_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output ffba_pkg::rsp_t                rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffba_pkg::APB_AW-1:0]   paddr,
  input  logic [ffba_pkg::APB_DW-1:0]   pwdata,
  output logic [ffba_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ffba_pkg::*;

  logic [HEAP_BASE_W-1:0] heap_base;
  logic                   reg_sel;
  cmd_t                   cmd;
  sts_t                   sts;

  // ---------------- configuration register
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RST;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_HEAP_BASE)) begin
      heap_base <= pwdata[HEAP_BASE_W-1:0];
    end
  end

  always_comb begin
    if (reg_sel == REG_HEAP_BASE) begin
      prdata = APB_DW'(heap_base);
    end else begin
      prdata = '0;
    end
  end

  // ---------------- controller and datapath
  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .heap_base(heap_base),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .rsp      (rsp),
    .rsp_stall(rsp_stall)
  );

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap block allocator. Requests are
// planned against a shadow heap so that most frees name live allocations.
// A driver and a monitor handle the two channels with random idling. Every
// result is checked against a second heap mirror that is updated at each
// accepted request. heap_base is moved between phases over the APB port.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int BLOCK_BYTES = DEF_BLOCK_BYTES;
  localparam int BLOCK_COUNT = DEF_BLOCK_COUNT;
  localparam int HEAP_BYTES  = BLOCK_BYTES * BLOCK_COUNT;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int PHASE_ITEMS = 300;
  localparam logic [APB_AW-1:0] ADDR_HEAP_BASE = APB_AW'(4 * int'(REG_HEAP_BASE));

  typedef mark_e heap_map_t [BLOCK_COUNT];

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  req_t              req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  rsp_t              rsp;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // plan_map runs ahead while requests are queued, dut_map follows transfers
  heap_map_t    plan_map;
  heap_map_t    dut_map;
  logic [15:0]  plan_base = HEAP_BASE_RST;
  logic [15:0]  dut_base  = HEAP_BASE_RST;
  int           live_q[$];
  req_t         request_q[$];
  rsp_t         outcome_q[$];
  int           errors = 0;
  bit           no_idle = 1'b0;
  int           quiet_cycles = 0;

  first_fit_heap_block_allocator #(
    .BLOCK_BYTES(BLOCK_BYTES),
    .BLOCK_COUNT(BLOCK_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  // outcome of one request on a heap, map updated in place
  function automatic rsp_t heap_outcome(inout heap_map_t map, input logic [15:0] base,
                                        input req_t r);
    rsp_t        o;
    int          run;
    int          start;
    int          cnt;
    int          b;
    bit          found;
    bit          stop;
    mark_e       m;
    logic [31:0] off;
    o = '0;
    start = 0;
    cnt = 0;
    if (r.operation == OP_ALLOC) begin
      o.status = STAT_ALLOC_FAIL;
      if (r.request_size > 0 && r.request_size <= HEAP_BYTES) begin
        run = 0;
        found = 1'b0;
        for (int i = 0; i < BLOCK_COUNT && !found; i++) begin
          if (map[i] == MARK_FREE) begin
            if (run == 0) start = i;
            run += BLOCK_BYTES;
            if (run >= r.request_size) begin
              found = 1'b1;
              cnt = i - start + 1;
            end
          end else begin
            run = 0;
          end
        end
        if (found) begin
          if (cnt == 1) begin
            map[start] = MARK_SINGLE;
          end else begin
            for (int k = 0; k < cnt; k++) begin
              if (k == 0) map[start + k] = MARK_FIRST;
              else if (k == cnt - 1) map[start + k] = MARK_LAST;
              else map[start + k] = MARK_MID;
            end
          end
          o.granted_address = GRANT_W'(32'(base) + 32'(start * BLOCK_BYTES));
          o.status = STAT_OK;
        end
      end
    end else begin
      o.status = STAT_ILLEGAL_FREE;
      off = r.free_address - 32'(base);
      if (off < HEAP_BYTES && off % BLOCK_BYTES == 0) begin
        b = int'(off / BLOCK_BYTES);
        if (map[b] == MARK_FIRST || map[b] == MARK_SINGLE) begin
          stop = 1'b0;
          while (!stop && b < BLOCK_COUNT) begin
            m = map[b];
            map[b] = MARK_FREE;
            stop = (m == MARK_LAST || m == MARK_SINGLE);
            b++;
          end
          o.status = STAT_OK;
        end
      end
    end
    return o;
  endfunction

  task automatic queue_item(input req_t r);
    rsp_t p;
    int   blk;
    int   hit[$];
    p = heap_outcome(plan_map, plan_base, r);
    if (p.status == STAT_OK) begin
      if (r.operation == OP_ALLOC) begin
        live_q.push_back((int'(p.granted_address) - int'(plan_base)) / BLOCK_BYTES);
      end else begin
        blk = int'((r.free_address - 32'(plan_base)) / BLOCK_BYTES);
        hit = live_q.find_first_index(x) with (x == blk);
        if (hit.size() != 0) live_q.delete(hit[0]);
      end
    end
    request_q.push_back(r);
  endtask

  // ignored fields carry random content
  task automatic queue_alloc(input logic [31:0] size);
    req_t r;
    r.operation    = OP_ALLOC;
    r.request_size = size;
    r.free_address = $urandom;
    queue_item(r);
  endtask

  task automatic queue_free(input logic [31:0] addr);
    req_t r;
    r.operation    = OP_FREE;
    r.request_size = $urandom;
    r.free_address = addr;
    queue_item(r);
  endtask

  task automatic queue_random(input int n);
    int          sel;
    int          pick;
    logic [31:0] base32;
    for (int j = 0; j < n; j++) begin
      base32 = 32'(plan_base);
      sel = $urandom_range(99);
      pick = $urandom_range(99);
      if (sel < 48 || live_q.size() == 0) begin
        if (pick < 70) queue_alloc($urandom_range(320, 1));
        else if (pick < 85) queue_alloc($urandom_range(HEAP_BYTES, 321));
        else if (pick < 93) begin
          case ($urandom_range(5))
            0: queue_alloc(0);
            1: queue_alloc(1);
            2: queue_alloc(BLOCK_BYTES);
            3: queue_alloc(BLOCK_BYTES + 1);
            4: queue_alloc(HEAP_BYTES);
            default: queue_alloc(HEAP_BYTES + 1);
          endcase
        end else queue_alloc($urandom);
      end else begin
        if (pick < 72) begin
          queue_free(base32 + 32'(live_q[$urandom_range(live_q.size() - 1)] * BLOCK_BYTES));
        end else if (pick < 82) begin
          queue_free(base32 + 32'($urandom_range(BLOCK_COUNT - 1) * BLOCK_BYTES));
        end else if (pick < 91) begin
          queue_free(base32 + 32'($urandom_range(HEAP_BYTES - 1)));
        end else begin
          queue_free($urandom);
        end
      end
    end
  endtask

  task automatic drain();
    while (request_q.size() != 0 || outcome_q.size() != 0 || req_valid) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_HEAP_BASE;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_heap_base(input logic [15:0] value);
    logic [APB_DW-1:0] rd;
    drain();
    repeat (4) @(posedge clk);
    // upper bits of the write data fall outside the register
    apb_access(1'b1, {16'($urandom), value}, rd);
    plan_base = value;
    dut_base  = value;
    apb_access(1'b0, '0, rd);
    if (rd !== APB_DW'(value)) begin
      $error("heap_base: expected %h, actual %h", APB_DW'(value), rd);
      errors++;
    end
  endtask

  // driver: the prediction is taken at each accepted transfer
  always @(posedge clk) begin : driver
    bit take;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      take = req_valid && !req_stall;
      if (take) outcome_q.push_back(heap_outcome(dut_map, dut_base, req));
      if (req_valid && !take) begin
        // held while stalled
      end else if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= 25)) begin
        req       <= request_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    int   hold_left;
    int   rsp_count;
    rsp_t e;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      rsp_count = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result: granted_address %h status %0d",
                 rsp.granted_address, rsp.status);
          errors++;
        end else begin
          e = outcome_q.pop_front();
          if (rsp.granted_address !== e.granted_address) begin
            $error("granted_address: expected %h, actual %h",
                   e.granted_address, rsp.granted_address);
            errors++;
          end
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, rsp.status);
            errors++;
          end
        end
        rsp_count++;
        // long hold-off so the block backs up and stalls its input
        if (rsp_count == 400 || rsp_count == 1000) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 25);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] b;
    foreach (plan_map[i]) plan_map[i] = MARK_FREE;
    foreach (dut_map[i]) dut_map[i] = MARK_FREE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset value of heap_base
    b = 32'(plan_base);
    queue_alloc(0);
    queue_alloc(32'hFFFF_FFFF);
    queue_alloc(32'h8000_0000);
    queue_alloc(HEAP_BYTES + 1);
    queue_alloc(32'h7FFF_FFFF);
    queue_alloc(HEAP_BYTES);
    queue_alloc(1);                           // heap full, no fit
    queue_free(b + BLOCK_BYTES);              // middle block
    queue_free(b + 1);                        // misaligned
    queue_free(b + HEAP_BYTES);               // past the heap
    queue_free(b - BLOCK_BYTES);              // below the heap, wraps
    queue_free(b);
    queue_free(b);                            // already free
    queue_alloc(1);
    queue_alloc(BLOCK_BYTES);
    queue_alloc(BLOCK_BYTES + 1);
    queue_alloc(HEAP_BYTES - 4 * BLOCK_BYTES); // run ends at the last block
    queue_free(b + BLOCK_BYTES);
    queue_alloc(BLOCK_BYTES + 1);             // only one free block
    queue_alloc(BLOCK_BYTES);
    queue_free(b + 4 * BLOCK_BYTES);
    queue_free(b + 2 * BLOCK_BYTES);
    queue_free(32'hFFFF_FFFF);
    queue_free(b);
    queue_free(b + BLOCK_BYTES);

    set_heap_base(16'h0000);
    queue_random(PHASE_ITEMS);
    set_heap_base(16'hFFFF);
    no_idle = 1'b1;
    queue_random(PHASE_ITEMS);
    drain();
    no_idle = 1'b0;
    set_heap_base(16'($urandom));
    queue_random(PHASE_ITEMS);
    set_heap_base(HEAP_BASE_RST);
    queue_random(PHASE_ITEMS);

    drain();
    repeat (300) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
